FILE: hdl/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

  // Queue depth between the classifier and the result sequencer
  localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

  // Character codes of interest
  localparam logic [7:0] CHAR_PAD       = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
  localparam logic [7:0] LOWER_OFFSET   = 8'd71;  // 'a' - 26
  localparam logic [7:0] DIGIT_OFFSET   = 8'd4;   // 52 - '0', added

  localparam logic [5:0] SEXTET_PLUS    = 6'd62;
  localparam logic [5:0] SEXTET_SLASH   = 6'd63;

  // Status codes on the final result
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_LEN = 2'd1;
  localparam logic [1:0] STAT_BAD_PAD = 2'd2;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // Work handed from the classifier to the result sequencer
  typedef struct packed {
    logic [1:0]  nbytes;      // data bytes to emit, 0..3
    logic [23:0] word;        // completed group, first byte in the top bits
    logic        has_status;  // a status result follows the bytes
    logic [1:0]  status;
    logic [15:0] count;
  } job_t;

  // Queue fill state seen at the top level
  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_stat_t;

  // Map one character to its alphabet value; '=' counts as value zero
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      t = c - CHAR_UPPER_A;
      r.ok = 1'b1;
      r.val = t[5:0];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      t = c - LOWER_OFFSET;
      r.ok = 1'b1;
      r.val = t[5:0];
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      t = c + DIGIT_OFFSET;
      r.ok = 1'b1;
      r.val = t[5:0];
    end else if (c == CHAR_PLUS) begin
      r.ok = 1'b1;
      r.val = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      r.ok = 1'b1;
      r.val = SEXTET_SLASH;
    end else if (c == CHAR_PAD) begin
      r.ok = 1'b1;
      r.val = '0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/b64d_front.sv
`timescale 1ns / 1ps

module b64d_front import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [17:0] group_q, group_d;
  logic [1:0]  fill_q, fill_d;
  logic [2:0]  pad_q, pad_d;
  logic [1:0]  mod4_q, mod4_d;
  logic        any_q, any_d;
  logic        done_q, done_d;
  logic        perr_q, perr_d;
  logic [15:0] total_q, total_d;

  logic        accept;
  sextet_t     sx;
  logic        is_pad;
  logic [2:0]  pad_nxt;
  logic [1:0]  nb;
  logic [16:0] sum;
  logic [1:0]  status;

  assign accept = in_valid_i & in_ready_i;
  assign sx     = sextet_of(char_code_i);
  assign is_pad = (char_code_i == CHAR_PAD);

  // Group assembly, padding and length tracking for one character
  always_comb begin
    group_d = group_q;
    fill_d  = fill_q;
    pad_d   = pad_q;
    mod4_d  = mod4_q;
    any_d   = any_q;
    done_d  = done_q;
    perr_d  = perr_q;
    total_d = total_q;
    nb      = '0;
    pad_nxt = pad_q + {2'b00, is_pad};
    job_o   = '0;
    sum     = '0;
    status  = STAT_OK;

    if (sx.ok) begin
      any_d  = 1'b1;
      mod4_d = mod4_q + 2'd1;
      if (!done_q) begin
        if (fill_q != 2'd3) begin
          group_d = {group_q[11:0], sx.val};
          fill_d  = fill_q + 2'd1;
          pad_d   = pad_nxt;
        end else begin
          if (pad_nxt >= 3'd3) begin
            perr_d = 1'b1;
            done_d = 1'b1;
          end else begin
            nb = 2'd3 - pad_nxt[1:0];
            if (pad_nxt != 3'd0) begin
              done_d = 1'b1;
            end
          end
          group_d = '0;
          fill_d  = '0;
          pad_d   = '0;
        end
      end
    end

    // Saturating byte total
    sum = {1'b0, total_q} + {15'd0, nb};
    if (sum[16]) begin
      total_d = COUNT_MAX;
    end else begin
      total_d = sum[15:0];
    end

    // Length error takes precedence over padding error
    if (!any_d || mod4_d != 2'd0) begin
      status = STAT_BAD_LEN;
    end else if (perr_d) begin
      status = STAT_BAD_PAD;
    end

    job_o.nbytes     = nb;
    job_o.word       = {group_q, sx.val};
    job_o.has_status = last_char_i;
    job_o.status     = status;
    job_o.count      = total_d;

    // End of message: back to the reset state
    if (last_char_i) begin
      group_d = '0;
      fill_d  = '0;
      pad_d   = '0;
      mod4_d  = '0;
      any_d   = 1'b0;
      done_d  = 1'b0;
      perr_d  = 1'b0;
      total_d = '0;
    end
  end

  // Only characters that cause results enter the queue
  assign push_o = accept & ((nb != 2'd0) | last_char_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      fill_q  <= '0;
      pad_q   <= '0;
      mod4_q  <= '0;
      any_q   <= 1'b0;
      done_q  <= 1'b0;
      perr_q  <= 1'b0;
      total_q <= '0;
    end else if (accept) begin
      group_q <= group_d;
      fill_q  <= fill_d;
      pad_q   <= pad_d;
      mod4_q  <= mod4_d;
      any_q   <= any_d;
      done_q  <= done_d;
      perr_q  <= perr_d;
      total_q <= total_d;
    end
  end

endmodule

FILE: hdl/b64d_queue.sv
`timescale 1ns / 1ps

module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        push_job_i,
  input  logic        pop_i,
  output job_t        pop_job_o,
  output queue_stat_t stat_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  job_t          entries_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign stat_o.full  = (cnt_q == FULL_CNT);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign stat_o.push  = push_i;
  assign stat_o.pop   = pop_i;
  assign pop_job_o    = entries_q[rd_ptr_q];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: hdl/b64d_back.sv
`timescale 1ns / 1ps

module b64d_back import b64d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,
  output logic        m_tlast_o,
  output logic        m_tuser_o
);

  logic        cur_valid_q, cur_valid_d;
  job_t        cur_q, cur_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic        out_last_q, out_last_d;
  logic        out_kind_q, out_kind_d;

  logic        load_out;
  logic        job_end;
  logic        take_job;
  logic [7:0]  byte_sel;

  assign load_out = cur_valid_q & (~out_valid_q | m_tready_i);
  assign job_end  = cur_q.has_status ? (idx_q == cur_q.nbytes)
                                     : (idx_q == cur_q.nbytes - 2'd1);
  assign take_job = ~cur_valid_q | (load_out & job_end);
  assign job_pop_o = take_job & job_valid_i;

  // Byte of the group for the current result, first byte highest
  always_comb begin
    case (idx_q)
      2'd0:    byte_sel = cur_q.word[23:16];
      2'd1:    byte_sel = cur_q.word[15:8];
      2'd2:    byte_sel = cur_q.word[7:0];
      default: byte_sel = '0;
    endcase
  end

  // Walk the results of the held job
  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    if (take_job) begin
      cur_valid_d = job_valid_i;
      cur_d       = job_i;
      idx_d       = '0;
    end else if (load_out) begin
      idx_d = idx_q + 2'd1;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_kind_d  = out_kind_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_last_d  = job_end;
      if (idx_q < cur_q.nbytes) begin
        out_kind_d = KIND_DATA;
        out_data_d = {24'd0, byte_sel};
      end else begin
        out_kind_d = KIND_STATUS;
        out_data_d = {6'd0, cur_q.count, cur_q.status, 8'd0};
      end
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_kind_q <= out_kind_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_kind_q;

endmodule

FILE: hdl/base64_stream_decoder.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+-------------------------------------------
// s_       | in  | s_tvalid_i/tready_o | tdata[7:0] char_code, tlast last_char
// m_       | out | m_tvalid_o/tready_i | tdata data_byte,status,decoded_count;
//          |     |                     | tuser kind, tlast end_of_run
//
// One character is accepted per cycle while the job queue has room.
// Results leave at one per cycle from the output register when m_tready_i is high;
// a character that completes a group with a status makes up to four, so the queue
// depth (QUEUE_DEPTH) sets how far the input side can run ahead of the output side.
// A result passes the job queue, held-job register and output register in turn.
// Reset (rst_ni low) clears all control state; no clearing pass is needed.

module base64_stream_decoder import b64d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] char_code
  input  logic        s_tlast_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [7:0] data_byte, [9:8] status,
                                   // [25:10] decoded_count, [31:26] zero
  output logic        m_tlast_o,
  output logic        m_tuser_o    // [0] kind
);

  logic        push;
  job_t        push_job;
  job_t        pop_job;
  logic        pop;
  queue_stat_t qstat;

  assign s_tready_o = ~qstat.full;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_i  (s_tready_o),
    .char_code_i (s_tdata_i),
    .last_char_i (s_tlast_i),
    .push_o      (push),
    .job_o       (push_job)
  );

  b64d_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .stat_o     (qstat)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (~qstat.empty),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .m_tuser_o   (m_tuser_o)
  );

  // Queue is never written when full nor read when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) qstat.push |-> !qstat.full)
    else $error("job queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) qstat.pop |-> !qstat.empty)
    else $error("job queue underflow");

  // Status transaction closes its run and carries a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o == KIND_STATUS) |->
      (m_tlast_o && m_tdata_o[9:8] != 2'd3 && m_tdata_o[7:0] == 8'd0))
    else $error("malformed status transaction");

  // Data transactions carry no status or count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o == KIND_DATA) |-> (m_tdata_o[31:8] == 24'd0))
    else $error("data transaction with status bits set");

endmodule
